### sv/hc3_pkg.sv
package hc3_pkg;

    localparam int MODULUS = 26;
    localparam logic [4:0] PAD_LETTER = 5'd23;
    localparam logic [7:0] FOLD_BIAS = 8'(6 * MODULUS);

    localparam logic [14:0] KEY_ROW_ZERO_RESET = 15'd1024;
    localparam logic [14:0] KEY_ROW_ONE_RESET  = 15'd32;
    localparam logic [14:0] KEY_ROW_TWO_RESET  = 15'd1;

    localparam logic [1:0] CFG_KEY_ROW_ZERO = 2'd0;
    localparam logic [1:0] CFG_KEY_ROW_ONE  = 2'd1;
    localparam logic [1:0] CFG_KEY_ROW_TWO  = 2'd2;
    localparam logic [1:0] CFG_DECRYPT_MODE = 2'd3;

    localparam logic [4:0] BUILD_DET_FIRST = 5'd18;
    localparam logic [4:0] BUILD_DET_LAST  = 5'd20;
    localparam logic [4:0] BUILD_INV_FIRST = 5'd21;
    localparam logic [4:0] BUILD_LAST      = 5'd29;

    localparam logic [1:0] COL_LAST = 2'd2;
    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] FILL_LAST = 2'd2;

    typedef enum logic [1:0] {
        A_KEY,
        A_GROUP,
        A_DINV
    } a_src_t;

    typedef enum logic [1:0] {
        B_KEY,
        B_INV,
        B_MATRIX
    } b_src_t;

    typedef struct packed {
        logic       take_item;
        logic       store_letter;
        logic       mac_en;
        logic       mac_first;
        logic       mac_neg;
        a_src_t     a_sel;
        logic [3:0] a_idx;
        b_src_t     b_sel;
        logic [3:0] b_idx;
        logic       wr_inv;
        logic       wr_det;
        logic [3:0] dst_idx;
        logic       set_ready;
        logic       load_err;
        logic       load_row;
        logic       row_last;
    } hc3_cmd_t;

    typedef struct packed {
        logic inv_ready;
        logic invertible;
        logic group_done;
        logic out_free;
    } hc3_status_t;

    function automatic logic [4:0] red26(input logic [4:0] v);
        return (v >= 5'(MODULUS)) ? v - 5'(MODULUS) : v;
    endfunction

    // valid for v below 8 * MODULUS
    function automatic logic [4:0] mod26_byte(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'(4 * MODULUS))
        begin
            r = r - 8'(4 * MODULUS);
        end
        if (r >= 8'(2 * MODULUS))
        begin
            r = r - 8'(2 * MODULUS);
        end
        if (r >= 8'(MODULUS))
        begin
            r = r - 8'(MODULUS);
        end
        return r[4:0];
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic logic [4:0] inv26(input logic [4:0] d);
        logic [4:0] r;
        unique case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // inverse build sequence: adjugate pairs, determinant, scaling by its inverse
    function automatic hc3_cmd_t build_cmd(input logic [4:0] step);
        hc3_cmd_t   c;
        logic [3:0] i;
        logic [3:0] p1a;
        logic [3:0] p1b;
        logic [3:0] p2a;
        logic [3:0] p2b;
        logic [4:0] off;
        c   = '0;
        i   = step[4:1];
        p1a = 4'd0;
        p1b = 4'd0;
        p2a = 4'd0;
        p2b = 4'd0;
        unique case (i)
            4'd0:
            begin
                p1a = 4'd8; p1b = 4'd4; p2a = 4'd7; p2b = 4'd5;
            end
            4'd1:
            begin
                p1a = 4'd7; p1b = 4'd2; p2a = 4'd8; p2b = 4'd1;
            end
            4'd2:
            begin
                p1a = 4'd5; p1b = 4'd1; p2a = 4'd4; p2b = 4'd2;
            end
            4'd3:
            begin
                p1a = 4'd6; p1b = 4'd5; p2a = 4'd8; p2b = 4'd3;
            end
            4'd4:
            begin
                p1a = 4'd8; p1b = 4'd0; p2a = 4'd6; p2b = 4'd2;
            end
            4'd5:
            begin
                p1a = 4'd3; p1b = 4'd2; p2a = 4'd5; p2b = 4'd0;
            end
            4'd6:
            begin
                p1a = 4'd7; p1b = 4'd3; p2a = 4'd6; p2b = 4'd4;
            end
            4'd7:
            begin
                p1a = 4'd6; p1b = 4'd1; p2a = 4'd7; p2b = 4'd0;
            end
            4'd8:
            begin
                p1a = 4'd4; p1b = 4'd0; p2a = 4'd3; p2b = 4'd1;
            end
            default:
            begin
                p1a = 4'd0; p1b = 4'd0; p2a = 4'd0; p2b = 4'd0;
            end
        endcase
        c.mac_en = 1'b1;
        if (step < BUILD_DET_FIRST)
        begin
            c.a_sel = A_KEY;
            c.b_sel = B_KEY;
            if (!step[0])
            begin
                c.mac_first = 1'b1;
                c.a_idx     = p1a;
                c.b_idx     = p1b;
            end
            else
            begin
                c.mac_neg = 1'b1;
                c.a_idx   = p2a;
                c.b_idx   = p2b;
                c.wr_inv  = 1'b1;
                c.dst_idx = i;
            end
        end
        else if (step <= BUILD_DET_LAST)
        begin
            off         = step - BUILD_DET_FIRST;
            c.a_sel     = A_KEY;
            c.a_idx     = 4'(off) * 4'd3;
            c.b_sel     = B_INV;
            c.b_idx     = 4'(off);
            c.mac_first = (step == BUILD_DET_FIRST);
            c.wr_det    = (step == BUILD_DET_LAST);
        end
        else
        begin
            off         = step - BUILD_INV_FIRST;
            c.a_sel     = A_DINV;
            c.b_sel     = B_INV;
            c.b_idx     = 4'(off);
            c.mac_first = 1'b1;
            c.wr_inv    = 1'b1;
            c.dst_idx   = 4'(off);
        end
        return c;
    endfunction

endpackage

### sv/hill_cipher_3x3_mod26.sv
// 3x3 Hill cipher mod 26. Letters (0..25, larger codes are reduced mod 26) come in one beat
// each and are collected in groups of three; a group closed early by last is padded with x.
// Every product runs through a single 5x5 multiply-accumulate unit with a mod 26 fold, one
// product per cycle while the output is not stalled. Each letter beat is accepted, then
// written into the group; a full group then runs the nine products, and the three results
// leave one per row. After any register write, the first letter also waits while the same
// unit forms the adjugate, the determinant and the inverse key.
// If the determinant shares a factor with 26, every letter yields one beat with key_error set
// and out_letter zero. A stalled result holds the output register.
module hill_cipher_3x3_mod26
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  letter,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  out_letter,
    output logic        out_last,
    output logic        key_error,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    hc3_pkg::hc3_cmd_t    cmd;
    hc3_pkg::hc3_status_t status;

    hc3_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hc3_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .letter     (letter),
        .last       (last),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_letter (out_letter),
        .out_last   (out_last),
        .key_error  (key_error)
    );

    a_error_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_error) |-> (out_letter == 5'd0))
        else $error("error beat carries a nonzero letter");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_letter < 5'(hc3_pkg::MODULUS)))
        else $error("result letter out of range");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous beat still in work");

endmodule

### sv/hc3_datapath.sv
module hc3_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          letter,
    input  logic                last,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [14:0]         cfg_data,
    input  hc3_pkg::hc3_cmd_t   cmd,
    output hc3_pkg::hc3_status_t status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [4:0]          out_letter,
    output logic                out_last,
    output logic                key_error
);

    logic [14:0] key_row_reg [3];
    logic        decrypt_reg;
    logic        inv_ready_reg;

    logic [4:0]  letter_reg;
    logic        last_reg;
    logic [4:0]  group_reg [3];
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;

    logic [4:0]  inv_reg [9];
    logic [4:0]  det_reg;
    logic [4:0]  acc_reg;
    logic [4:0]  acc_next;

    logic        out_valid_reg;
    logic [4:0]  out_letter_reg;
    logic        out_last_reg;
    logic        key_error_reg;

    logic [4:0]  key_ent [9];
    logic [4:0]  dinv;
    logic [4:0]  a_val;
    logic [4:0]  b_val;
    logic [9:0]  prod;
    logic [7:0]  fold;
    logic [7:0]  base;
    logic [7:0]  sum;
    logic        group_done;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                key_ent[r * 3 + c] = hc3_pkg::red26(key_row_reg[r][5 * c +: 5]);
            end
        end
    end

    assign dinv = hc3_pkg::inv26(det_reg);

    always_comb
    begin
        case (cmd.a_sel)
            hc3_pkg::A_KEY:   a_val = key_ent[cmd.a_idx];
            hc3_pkg::A_GROUP: a_val = group_reg[cmd.a_idx[1:0]];
            hc3_pkg::A_DINV:  a_val = dinv;
            default:          a_val = 5'd0;
        endcase
    end

    always_comb
    begin
        case (cmd.b_sel)
            hc3_pkg::B_KEY:    b_val = key_ent[cmd.b_idx];
            hc3_pkg::B_INV:    b_val = inv_reg[cmd.b_idx];
            hc3_pkg::B_MATRIX: b_val = decrypt_reg ? inv_reg[cmd.b_idx] : key_ent[cmd.b_idx];
            default:           b_val = 5'd0;
        endcase
    end

    // 32 is 6 mod 26, so the product folds to at most 145
    assign prod = 10'(a_val) * 10'(b_val);
    assign fold = 8'({prod[9:5], 2'b00}) + 8'({prod[9:5], 1'b0}) + 8'(prod[4:0]);
    assign base = cmd.mac_first ? 8'd0 : 8'(acc_reg);
    assign sum  = cmd.mac_neg ? base + hc3_pkg::FOLD_BIAS - fold : base + fold;
    assign acc_next = hc3_pkg::mod26_byte(sum);

    assign group_done = (fill_reg == hc3_pkg::FILL_LAST) || last_reg;
    assign fill_next  = group_done ? 2'd0 : fill_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_row_reg[0] <= hc3_pkg::KEY_ROW_ZERO_RESET;
            key_row_reg[1] <= hc3_pkg::KEY_ROW_ONE_RESET;
            key_row_reg[2] <= hc3_pkg::KEY_ROW_TWO_RESET;
            decrypt_reg    <= 1'b0;
            inv_ready_reg  <= 1'b0;
            fill_reg       <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                inv_ready_reg <= 1'b0;
                unique case (cfg_index)
                    hc3_pkg::CFG_KEY_ROW_ZERO: key_row_reg[0] <= cfg_data;
                    hc3_pkg::CFG_KEY_ROW_ONE:  key_row_reg[1] <= cfg_data;
                    hc3_pkg::CFG_KEY_ROW_TWO:  key_row_reg[2] <= cfg_data;
                    hc3_pkg::CFG_DECRYPT_MODE: decrypt_reg    <= cfg_data[0];
                    default:                   decrypt_reg    <= decrypt_reg;
                endcase
            end
            else if (cmd.set_ready)
            begin
                inv_ready_reg <= 1'b1;
            end
            if (cmd.store_letter)
            begin
                fill_reg <= fill_next;
            end
            if (cmd.load_err || cmd.load_row)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            letter_reg <= hc3_pkg::red26(letter);
            last_reg   <= last;
        end
        if (cmd.store_letter)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) == fill_reg)
                begin
                    group_reg[i] <= letter_reg;
                end
                else if (2'(i) > fill_reg && last_reg)
                begin
                    group_reg[i] <= hc3_pkg::PAD_LETTER;
                end
            end
        end
        if (cmd.mac_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.mac_en && cmd.wr_inv)
        begin
            inv_reg[cmd.dst_idx] <= acc_next;
        end
        if (cmd.mac_en && cmd.wr_det)
        begin
            det_reg <= acc_next;
        end
        if (cmd.load_err)
        begin
            out_letter_reg <= 5'd0;
            out_last_reg   <= last_reg;
            key_error_reg  <= 1'b1;
        end
        else if (cmd.load_row)
        begin
            out_letter_reg <= acc_next;
            out_last_reg   <= cmd.row_last && last_reg;
            key_error_reg  <= 1'b0;
        end
    end

    assign status.inv_ready  = inv_ready_reg;
    assign status.invertible = det_reg[0] && (det_reg != 5'd13);
    assign status.group_done = group_done;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_letter = out_letter_reg;
    assign out_last   = out_last_reg;
    assign key_error  = key_error_reg;

endmodule

### sv/hc3_ctrl.sv
module hc3_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hc3_pkg::hc3_status_t status,
    output hc3_pkg::hc3_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_DISPATCH,
        ST_MAC
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;
    logic [1:0] row_reg;
    logic [1:0] row_next;
    logic [1:0] col_reg;
    logic [1:0] col_next;
    logic [3:0] mac_idx;

    assign in_ready = (state_reg == ST_IDLE);
    assign mac_idx  = 4'(row_reg) * 4'd3 + 4'(col_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    if (status.inv_ready)
                    begin
                        state_next = ST_DISPATCH;
                    end
                    else
                    begin
                        state_next = ST_BUILD;
                        step_next  = 5'd0;
                    end
                end
            end
            ST_BUILD:
            begin
                cmd = hc3_pkg::build_cmd(step_reg);
                if (step_reg == hc3_pkg::BUILD_LAST)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = ST_DISPATCH;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DISPATCH:
            begin
                if (!status.invertible)
                begin
                    if (status.out_free)
                    begin
                        cmd.load_err = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.store_letter = 1'b1;
                    if (status.group_done)
                    begin
                        state_next = ST_MAC;
                        row_next   = 2'd0;
                        col_next   = 2'd0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_first = (col_reg == 2'd0);
                cmd.a_sel     = hc3_pkg::A_GROUP;
                cmd.a_idx     = 4'(col_reg);
                cmd.b_sel     = hc3_pkg::B_MATRIX;
                cmd.b_idx     = mac_idx;
                if (col_reg == hc3_pkg::COL_LAST)
                begin
                    if (status.out_free)
                    begin
                        cmd.mac_en   = 1'b1;
                        cmd.load_row = 1'b1;
                        cmd.row_last = (row_reg == hc3_pkg::ROW_LAST);
                        col_next     = 2'd0;
                        if (row_reg == hc3_pkg::ROW_LAST)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            row_next = row_reg + 2'd1;
                        end
                    end
                end
                else
                begin
                    cmd.mac_en = 1'b1;
                    col_next   = col_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 5'd0;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

endmodule
